// ===== sv/stsh_pkg.sv =====
// ============================================================================
// stsh_pkg - shared types and constants of the stereo transient shaper
// Holds the sequencer state type, register indexes and the fixed-point
// constants used by the shaper datapath.
// ============================================================================
package stsh_pkg;

   localparam int SW = 24;

   localparam logic [22:0] SMAX       = 23'h7F_FFFF;
   localparam logic [23:0] GAIN_MAX   = 24'hFF_FFFF;
   localparam logic [23:0] GAIN_UNITY = 24'h10_0000;
   localparam logic [31:0] Q30        = 32'h4000_0000;

   localparam logic [15:0] ATT_FAST = 16'd12325;
   localparam logic [15:0] GAIN_ATT = 16'd2675;
   localparam logic [15:0] GAIN_REL = 16'd91;

   localparam logic signed [32:0] DB_PER_LOG2   = 33'sd394566;
   localparam logic signed [32:0] LOG2_10_DIV20 = 33'sd10885;
   localparam logic signed [32:0] LN2_Q30       = 33'sd744261118;
   localparam logic signed [32:0] DIV5_RECIP    = 33'sd52429;

   localparam logic [16:0] LINK_MIN   = 17'd328;
   localparam logic [16:0] FULL_SCALE = 17'd65536;
   localparam logic [11:0] RATIO_LIMIT = 12'd2560;
   localparam logic [25:0] RATIO_HALF  = 26'd1280;

   localparam logic [4:0] SERIES_LAST = 5'd24;
   localparam logic [4:0] LOG_LAST    = 5'd15;
   localparam logic [4:0] DIV_LAST    = 5'd30;

   localparam logic [2:0] REG_MODE      = 3'd0;
   localparam logic [2:0] REG_FAST_REL  = 3'd1;
   localparam logic [2:0] REG_SLOW_ATT  = 3'd2;
   localparam logic [2:0] REG_SLOW_REL  = 3'd3;
   localparam logic [2:0] REG_LINK      = 3'd4;
   localparam logic [2:0] REG_ATT_GAIN  = 3'd5;
   localparam logic [2:0] REG_SUS_GAIN  = 3'd6;
   localparam logic [2:0] REG_WET_DRY   = 3'd7;

   typedef enum logic [4:0] {
      S_IDLE, S_ENV_F, S_ENV_F_UPD, S_ENV_S, S_ENV_S_UPD, S_LINK, S_LINK_UPD,
      S_LOG_INIT, S_LOG_SQ, S_LOG_UPD, S_RATIO, S_RATIO_UPD, S_GDB, S_GDB_UPD,
      S_DIV5, S_DIV5_UPD, S_EXPE, S_EXPE_UPD, S_EXPX, S_EXPX_UPD, S_SER,
      S_SER_UPD, S_DIV, S_EXP_FIN, S_GAIN, S_GAIN_UPD, S_WET, S_WET_UPD,
      S_MIX, S_MIX_UPD, S_DONE
   } state_type;

   function automatic logic signed [65:0] rsr66(input logic signed [65:0] v,
                                                input int unsigned s);
      logic [65:0] mag;
      logic [65:0] r;
      mag = v[65] ? 66'(-v) : 66'(v);
      r = (mag + (66'd1 << (s - 1))) >> s;
      return v[65] ? -$signed(r) : $signed(r);
   endfunction

endpackage

// ===== sv/stsh_if.sv =====
// ============================================================================
// stsh_if - item channels of the stereo transient shaper
// Request channel carries a stereo input frame, response channel the result.
// ============================================================================
interface stsh_req_if;
   import stsh_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [SW-1:0] left_sample;
   logic signed [SW-1:0] right_sample;
   modport source (output valid, left_sample, right_sample, input ready);
   modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface stsh_rsp_if;
   import stsh_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [SW-1:0] left_out;
   logic signed [SW-1:0] right_out;
   modport source (output valid, left_out, right_out, input ready);
   modport sink   (input valid, left_out, right_out, output ready);
endinterface

// ===== sv/stereo_transient_shaper.sv =====
// ============================================================================
// stereo_transient_shaper - dual envelope transient shaper, stereo frames
// A small sequencer drives one shared multiplier and a serial divider
// through envelope, link, log, gain law, exponential and mix steps.
// ============================================================================
//  Channel  Direction  Contents
//  req_ch   in         left_sample, right_sample (Q1.23)
//  rsp_ch   out        left_out, right_out (Q1.23, saturated)
//  csr_*    in         write enable, register index, write data
//
// The time an item takes per processed channel is set by the
// 24-term exponential series whose every term passes the bit-serial divider.
// Ready is high only in idle; a finished result waits in the output register
// while the next item is accepted. Reset is synchronous and restores unity gain.
module stereo_transient_shaper (
   input  logic         clock,
   input  logic         reset,
   stsh_req_if.sink     req_ch,
   stsh_rsp_if.source   rsp_ch,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [16:0]  csr_wdata
);
   import stsh_pkg::*;

   state_type state_ff, state_in;

   logic               mode_ff;
   logic [15:0]        frel_ff, satt_ff, srel_ff;
   logic [16:0]        link_ff, wet_ff;
   logic signed [13:0] again_ff, sgain_ff;

   logic [22:0] fe_ff [2];
   logic [22:0] se_ff [2];
   logic [23:0] gn_ff [2];
   logic [22:0] det_f_ff [2];
   logic [22:0] det_s_ff [2];
   logic signed [23:0] x_ff [2];
   logic signed [23:0] y_ff [2];

   logic               ch_ff, sgn_ff, lsel_ff;
   logic [1:0]         lk_ff;
   logic [4:0]         it_ff, pp_ff, k_ff, rem_ff;
   logic [31:0]        mn_ff, sum_ff;
   logic [15:0]        fr_ff;
   logic signed [21:0] lg_ff;
   logic signed [12:0] ratio_ff;
   logic [16:0]        bq_ff;
   logic signed [14:0] gdb_ff;
   logic signed [20:0] e_ff;
   logic [30:0]        xarg_ff, term_ff, dn_ff;
   logic [23:0]        tgt_ff;
   logic signed [28:0] diff_ff;
   logic signed [65:0] prod_ff;

   logic               rsp_valid_ff;
   logic signed [23:0] rsp_left_ff, rsp_right_ff;

   logic signed [32:0] mul_a, mul_b;

   logic               last_ch, link_on, slow_sel, out_free;
   logic [16:0]        link_c, mix_c;
   logic signed [23:0] xc;
   logic [22:0]        lvl, env_cur, env_mag, env_new;
   logic               env_up;
   logic [15:0]        env_coef;
   logic signed [65:0] rnd16;
   logic [23:0]        step;
   logic               lk_slow, lk_ch;
   logic [22:0]        lmax, ldet, ldiff;
   logic [22:0]        lv;
   logic               det_zero;
   logic [4:0]         lp;
   logic [31:0]        lm_init, sq;
   logic [15:0]        fr_new;
   logic [20:0]        log_val;
   logic signed [65:0] r24, r8, r20, r16;
   logic [65:0]        r24_mag;
   logic signed [12:0] ratio_cl;
   logic signed [13:0] g_sel;
   logic [11:0]        rat_mag;
   logic [65:0]        gnum_mag;
   logic [25:0]        gnum_rnd;
   logic [15:0]        q5;
   logic [5:0]         r6;
   logic               ge;
   logic [4:0]         rem_new;
   logic [30:0]        dn_new;
   logic signed [4:0]  n_exp;
   logic [5:0]         s_exp;
   logic [32:0]        fin_rnd, fin_r;
   logic [23:0]        tgt_new;
   logic [23:0]        gcur, gmag, gnew;
   logic               gup;
   logic [15:0]        gcoef;
   logic signed [29:0] y_sum;
   logic signed [23:0] y_sat;

   // ---------------------------------------------------------------- helpers
   always_comb begin
      link_c   = (link_ff > FULL_SCALE) ? FULL_SCALE : link_ff;
      mix_c    = (wet_ff > FULL_SCALE) ? FULL_SCALE : wet_ff;
      last_ch  = !mode_ff || ch_ff;
      link_on  = mode_ff && (link_c >= LINK_MIN);
      out_free = !rsp_valid_ff || rsp_ch.ready;
      slow_sel = (state_ff == S_ENV_S) || (state_ff == S_ENV_S_UPD);

      xc = x_ff[ch_ff];
      if (xc[23]) begin
         lvl = (xc == 24'sh80_0000) ? SMAX : 23'(-xc);
      end else begin
         lvl = xc[22:0];
      end
      env_cur  = slow_sel ? se_ff[ch_ff] : fe_ff[ch_ff];
      env_up   = lvl > env_cur;
      env_mag  = env_up ? (lvl - env_cur) : (env_cur - lvl);
      env_coef = slow_sel ? (env_up ? satt_ff : srel_ff) : (env_up ? ATT_FAST : frel_ff);
      rnd16    = prod_ff + 66'sd32768;
      step     = 24'(rnd16 >>> 16);
      env_new  = sgn_ff ? (env_cur - step[22:0]) : (env_cur + step[22:0]);

      lk_slow = lk_ff[0];
      lk_ch   = lk_ff[1];
      lmax = lk_slow ? ((se_ff[0] > se_ff[1]) ? se_ff[0] : se_ff[1])
                     : ((fe_ff[0] > fe_ff[1]) ? fe_ff[0] : fe_ff[1]);
      ldet  = lk_slow ? det_s_ff[lk_ch] : det_f_ff[lk_ch];
      ldiff = lmax - ldet;

      lv       = lsel_ff ? det_s_ff[ch_ff] : det_f_ff[ch_ff];
      det_zero = (det_f_ff[ch_ff] == 23'd0) || (det_s_ff[ch_ff] == 23'd0);
      lp = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (lv[i]) lp = 5'(i);
      end
      lm_init = {9'd0, lv} << (5'd30 - lp);
      sq      = prod_ff[61:30];
      fr_new  = fr_ff | (16'd1 << it_ff[3:0]);
      log_val = {pp_ff, (sq[31] ? fr_new : fr_ff)};

      r24 = rsr66(prod_ff, 24);
      r8  = rsr66(prod_ff, 8);
      r20 = rsr66(prod_ff, 20);
      r16 = rsr66(prod_ff, 16);
      r24_mag = r24[65] ? 66'(-r24) : 66'(r24);
      if (r24_mag > 66'(RATIO_LIMIT)) begin
         ratio_cl = r24[65] ? -$signed({1'b0, RATIO_LIMIT}) : $signed({1'b0, RATIO_LIMIT});
      end else begin
         ratio_cl = 13'(r24);
      end

      g_sel    = (ratio_ff > 13'sd0) ? again_ff : sgain_ff;
      rat_mag  = ratio_ff[12] ? 12'(-ratio_ff) : 12'(ratio_ff);
      gnum_mag = prod_ff[65] ? 66'(-prod_ff) : 66'(prod_ff);
      gnum_rnd = 26'(gnum_mag) + RATIO_HALF;
      q5       = prod_ff[33:18];

      r6      = {rem_ff, dn_ff[30]};
      ge      = r6 >= {1'b0, k_ff};
      rem_new = ge ? 5'(r6 - {1'b0, k_ff}) : r6[4:0];
      dn_new  = {dn_ff[29:0], ge};

      n_exp   = e_ff[20:16];
      s_exp   = 6'(6'sd10 - 6'(n_exp));
      fin_rnd = {1'b0, sum_ff} + (33'd1 << (s_exp - 6'd1));
      fin_r   = fin_rnd >> s_exp;
      if (n_exp >= 5'sd10) begin
         tgt_new = GAIN_MAX;
      end else if (fin_r > 33'(GAIN_MAX)) begin
         tgt_new = GAIN_MAX;
      end else begin
         tgt_new = fin_r[23:0];
      end

      gcur  = gn_ff[ch_ff];
      gup   = tgt_ff > gcur;
      gmag  = gup ? (tgt_ff - gcur) : (gcur - tgt_ff);
      gcoef = gup ? GAIN_ATT : GAIN_REL;
      gnew  = sgn_ff ? (gcur - step) : (gcur + step);

      y_sum = 30'(xc) + 30'(r16);
      if (y_sum > 30'sd8388607) begin
         y_sat = 24'sh7F_FFFF;
      end else if (y_sum < -30'sd8388608) begin
         y_sat = 24'sh80_0000;
      end else begin
         y_sat = 24'(y_sum);
      end
   end

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_ch.valid) state_in = S_ENV_F;
         S_ENV_F:     state_in = S_ENV_F_UPD;
         S_ENV_F_UPD: state_in = S_ENV_S;
         S_ENV_S:     state_in = S_ENV_S_UPD;
         S_ENV_S_UPD: begin
            if (!last_ch) state_in = S_ENV_F;
            else if (link_on) state_in = S_LINK;
            else state_in = S_LOG_INIT;
         end
         S_LINK:      state_in = S_LINK_UPD;
         S_LINK_UPD:  state_in = (lk_ff == 2'd3) ? S_LOG_INIT : S_LINK;
         S_LOG_INIT:  state_in = det_zero ? S_GDB : S_LOG_SQ;
         S_LOG_SQ:    state_in = S_LOG_UPD;
         S_LOG_UPD: begin
            if (it_ff == 5'd0) state_in = lsel_ff ? S_RATIO : S_LOG_INIT;
            else state_in = S_LOG_SQ;
         end
         S_RATIO:     state_in = S_RATIO_UPD;
         S_RATIO_UPD: state_in = S_GDB;
         S_GDB:       state_in = (ratio_ff == 13'sd0) ? S_EXPE : S_GDB_UPD;
         S_GDB_UPD:   state_in = S_DIV5;
         S_DIV5:      state_in = S_DIV5_UPD;
         S_DIV5_UPD:  state_in = S_EXPE;
         S_EXPE:      state_in = S_EXPE_UPD;
         S_EXPE_UPD:  state_in = S_EXPX;
         S_EXPX:      state_in = S_EXPX_UPD;
         S_EXPX_UPD:  state_in = S_SER;
         S_SER:       state_in = S_SER_UPD;
         S_SER_UPD:   state_in = S_DIV;
         S_DIV: begin
            if (it_ff == 5'd0) state_in = (k_ff == SERIES_LAST) ? S_EXP_FIN : S_SER;
         end
         S_EXP_FIN:   state_in = S_GAIN;
         S_GAIN:      state_in = S_GAIN_UPD;
         S_GAIN_UPD:  state_in = S_WET;
         S_WET:       state_in = S_WET_UPD;
         S_WET_UPD:   state_in = S_MIX;
         S_MIX:       state_in = S_MIX_UPD;
         S_MIX_UPD:   state_in = last_ch ? S_DONE : S_LOG_INIT;
         S_DONE:      if (out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // --------------------------------------------------------------- outputs
   always_comb begin
      req_ch.ready = (state_ff == S_IDLE);
      mul_a = 33'sd0;
      mul_b = 33'sd0;
      unique case (state_ff)
         S_ENV_F, S_ENV_S: begin
            mul_a = $signed({10'd0, env_mag});
            mul_b = $signed({17'd0, env_coef});
         end
         S_LINK: begin
            mul_a = $signed({10'd0, ldiff});
            mul_b = $signed({16'd0, link_c});
         end
         S_LOG_SQ: begin
            mul_a = $signed({1'b0, mn_ff});
            mul_b = $signed({1'b0, mn_ff});
         end
         S_RATIO: begin
            mul_a = 33'(lg_ff);
            mul_b = DB_PER_LOG2;
         end
         S_GDB: begin
            mul_a = 33'(g_sel);
            mul_b = $signed({21'd0, rat_mag});
         end
         S_DIV5: begin
            mul_a = $signed({16'd0, bq_ff});
            mul_b = DIV5_RECIP;
         end
         S_EXPE: begin
            mul_a = 33'(gdb_ff);
            mul_b = LOG2_10_DIV20;
         end
         S_EXPX: begin
            mul_a = $signed({17'd0, e_ff[15:0]});
            mul_b = LN2_Q30;
         end
         S_SER: begin
            mul_a = $signed({2'd0, term_ff});
            mul_b = $signed({2'd0, xarg_ff});
         end
         S_GAIN: begin
            mul_a = $signed({9'd0, gmag});
            mul_b = $signed({17'd0, gcoef});
         end
         S_WET: begin
            mul_a = 33'(xc);
            mul_b = $signed({9'd0, gcur});
         end
         S_MIX: begin
            mul_a = 33'(diff_ff);
            mul_b = $signed({16'd0, mix_c});
         end
         default: begin
            mul_a = 33'sd0;
            mul_b = 33'sd0;
         end
      endcase
      rsp_ch.valid     = rsp_valid_ff;
      rsp_ch.left_out  = rsp_left_ff;
      rsp_ch.right_out = rsp_right_ff;
   end

   // ------------------------------------------------- control and state regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b1;
         frel_ff      <= 16'd1360;
         satt_ff      <= 16'd455;
         srel_ff      <= 16'd61;
         link_ff      <= 17'd0;
         again_ff     <= 14'sd0;
         sgain_ff     <= 14'sd0;
         wet_ff       <= FULL_SCALE;
         for (int c = 0; c < 2; c++) begin
            fe_ff[c] <= 23'd0;
            se_ff[c] <= 23'd0;
            gn_ff[c] <= GAIN_UNITY;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_MODE:     mode_ff  <= csr_wdata[0];
               REG_FAST_REL: frel_ff  <= csr_wdata[15:0];
               REG_SLOW_ATT: satt_ff  <= csr_wdata[15:0];
               REG_SLOW_REL: srel_ff  <= csr_wdata[15:0];
               REG_LINK:     link_ff  <= csr_wdata;
               REG_ATT_GAIN: again_ff <= $signed(csr_wdata[13:0]);
               REG_SUS_GAIN: sgain_ff <= $signed(csr_wdata[13:0]);
               REG_WET_DRY:  wet_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == S_ENV_F_UPD) fe_ff[ch_ff] <= env_new;
         if (state_ff == S_ENV_S_UPD) se_ff[ch_ff] <= env_new;
         if (state_ff == S_GAIN_UPD)  gn_ff[ch_ff] <= gnew;
         if ((state_ff == S_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (state_ff)
         S_IDLE: begin
            x_ff[0] <= req_ch.left_sample;
            x_ff[1] <= req_ch.right_sample;
            y_ff[1] <= req_ch.right_sample;
            ch_ff   <= 1'b0;
            lsel_ff <= 1'b0;
         end
         S_ENV_F, S_ENV_S, S_GAIN: sgn_ff <= (state_ff == S_GAIN) ? !gup : !env_up;
         S_ENV_F_UPD: det_f_ff[ch_ff] <= env_new;
         S_ENV_S_UPD: begin
            det_s_ff[ch_ff] <= env_new;
            lk_ff <= 2'd0;
            ch_ff <= !last_ch;
         end
         S_LINK: ;
         S_LINK_UPD: begin
            if (lk_slow) det_s_ff[lk_ch] <= ldet + step[22:0];
            else det_f_ff[lk_ch] <= ldet + step[22:0];
            lk_ff <= lk_ff + 2'd1;
         end
         S_LOG_INIT: begin
            ratio_ff <= 13'sd0;
            mn_ff    <= lm_init;
            pp_ff    <= lp;
            fr_ff    <= 16'd0;
            it_ff    <= LOG_LAST;
         end
         S_LOG_SQ: ;
         S_LOG_UPD: begin
            mn_ff <= sq[31] ? (sq >> 1) : sq;
            fr_ff <= sq[31] ? fr_new : fr_ff;
            it_ff <= it_ff - 5'd1;
            if (it_ff == 5'd0) begin
               lsel_ff <= !lsel_ff;
               lg_ff   <= lsel_ff ? (lg_ff - $signed({1'b0, log_val}))
                                  : $signed({1'b0, log_val});
            end
         end
         S_RATIO: ;
         S_RATIO_UPD: ratio_ff <= ratio_cl;
         S_GDB: gdb_ff <= 15'sd0;
         S_GDB_UPD: begin
            sgn_ff <= prod_ff[65];
            bq_ff  <= {1'b0, gnum_rnd[24:9]};
         end
         S_DIV5: ;
         S_DIV5_UPD: gdb_ff <= sgn_ff ? -$signed({1'b0, q5[13:0]}) : $signed({1'b0, q5[13:0]});
         S_EXPE: ;
         S_EXPE_UPD: e_ff <= 21'(r8);
         S_EXPX: ;
         S_EXPX_UPD: begin
            xarg_ff <= prod_ff[46:16];
            term_ff <= Q30[30:0];
            sum_ff  <= Q30;
            k_ff    <= 5'd1;
         end
         S_SER: ;
         S_SER_UPD: begin
            dn_ff  <= prod_ff[60:30];
            rem_ff <= 5'd0;
            it_ff  <= DIV_LAST;
         end
         S_DIV: begin
            dn_ff  <= dn_new;
            rem_ff <= rem_new;
            it_ff  <= it_ff - 5'd1;
            if (it_ff == 5'd0) begin
               term_ff <= dn_new;
               sum_ff  <= sum_ff + {1'b0, dn_new};
               k_ff    <= k_ff + 5'd1;
            end
         end
         S_EXP_FIN: tgt_ff <= tgt_new;
         S_GAIN_UPD, S_WET: ;
         S_WET_UPD: diff_ff <= 29'(r20) - 29'(xc);
         S_MIX: ;
         S_MIX_UPD: begin
            y_ff[ch_ff] <= y_sat;
            ch_ff       <= 1'b1;
            lsel_ff     <= 1'b0;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_left_ff  <= y_ff[0];
               rsp_right_ff <= y_ff[1];
            end
         end
         default: ;
      endcase
   end

endmodule
